@@ rtl/multi_resource_admission_control_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the admission control core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_RESOURCE_ADMISSION_CONTROL_CORE_MACROS_SVH
`define MULTI_RESOURCE_ADMISSION_CONTROL_CORE_MACROS_SVH

// property that must hold in the same cycle
`define MRAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define MRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mrac_pkg.sv @@
// ----------------------------------------------------------------------------
// mrac_pkg
// Types and constants of the multi-resource admission control core.
// ----------------------------------------------------------------------------
`default_nettype none

package mrac_pkg;

  localparam int NUM_TYPES   = 7;
  localparam int COUNT_WIDTH = 6;
  localparam int PEND_DEPTH  = 16;
  localparam int RUN_DEPTH   = 16;

  localparam int PEND_AW   = $clog2(PEND_DEPTH);
  localparam int FILL_W    = $clog2(PEND_DEPTH + 1);
  localparam int RUN_AW    = $clog2(RUN_DEPTH);
  localparam int TYPE_W    = $clog2(NUM_TYPES);
  localparam int RES_CNT_W = $clog2(NUM_TYPES + 1);
  localparam int CFG_IDX_W = 3;
  localparam int EVENT_W   = 3;
  localparam int CMD_W     = 2;

  typedef logic [NUM_TYPES-1:0][COUNT_WIDTH-1:0] cnt_vec_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_POLL   = 2'd2,
    CMD_STATUS = 2'd3
  } cmd_e;

  typedef enum logic [EVENT_W-1:0] {
    EV_QUEUED   = 3'd0,
    EV_REJECTED = 3'd1,
    EV_STARTED  = 3'd2,
    EV_RELEASED = 3'd3,
    EV_UNKNOWN  = 3'd4,
    EV_STATUS   = 3'd5
  } event_e;

endpackage

`default_nettype wire

@@ rtl/multi_resource_admission_control_core.sv @@
// ----------------------------------------------------------------------------
// multi_resource_admission_control_core
// Admits queued requests against per-type resource limits and tracks the
// running set in a 16-slot table.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in        in         in_valid_i/in_ready_o   command, finished_slot, count_type0..6
//   out       out        out_valid_o/out_ready_i event_res, task_slot, type_index,
//                                                running_count, last
//   cfg       in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i (limit_type0..6)
//
// an accepted item waits in the input register until no earlier result is pending
// or the last one is leaving, then executes in one pass over the fifo head, limit
// compares, free-slot search and the running table; its first result is then registered in the output register
// an item's results hold the input side until they have left through a free
// output port; a status query is the longest with seven results
// a stalled output port stalls execution and then the input port
// reset clears pointers, fill, slot valid bits, totals and limits; the fifo
// and running table storage is not cleared, only written entries are read
// cfg writes are taken every cycle
`default_nettype none

`include "multi_resource_admission_control_core_macros.svh"

module multi_resource_admission_control_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request side
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mrac_pkg::CMD_W-1:0]        command_i,
  input  logic [mrac_pkg::RUN_AW-1:0]       finished_slot_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type0_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type1_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type2_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type3_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type4_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type5_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  count_type6_i,
  // result side
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mrac_pkg::EVENT_W-1:0]      event_res_o,
  output logic [mrac_pkg::RUN_AW-1:0]       task_slot_o,
  output logic [mrac_pkg::TYPE_W-1:0]       type_index_o,
  output logic [mrac_pkg::COUNT_WIDTH-1:0]  running_count_o,
  output logic                              last_o,
  // limit registers
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mrac_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mrac_pkg::COUNT_WIDTH-1:0]  cfg_data_i
);

  // --------------------------------------------------------------------------
  // limit registers
  // --------------------------------------------------------------------------
  mrac_pkg::cnt_vec_t lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o &&
                 (cfg_index_i < mrac_pkg::CFG_IDX_W'(mrac_pkg::NUM_TYPES))) begin
      lim_q[cfg_index_i[mrac_pkg::TYPE_W-1:0]] <= cfg_data_i;
    end
  end

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  mrac_pkg::cnt_vec_t                in_cnt;
  logic                              in_vld_q;
  mrac_pkg::cmd_e                    in_cmd_q;
  logic [mrac_pkg::RUN_AW-1:0]       in_fslot_q;
  mrac_pkg::cnt_vec_t                in_cnt_q;
  logic                              in_go;
  logic                              exec_go;
  logic                              emit_go;

  assign in_cnt[0] = count_type0_i;
  assign in_cnt[1] = count_type1_i;
  assign in_cnt[2] = count_type2_i;
  assign in_cnt[3] = count_type3_i;
  assign in_cnt[4] = count_type4_i;
  assign in_cnt[5] = count_type5_i;
  assign in_cnt[6] = count_type6_i;

  // input register frees up in the cycle its item executes
  assign in_ready_o = !in_vld_q || exec_go;
  assign in_go      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_go) begin
      in_vld_q <= 1'b1;
    end else if (exec_go) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      in_cmd_q   <= mrac_pkg::cmd_e'(command_i);
      in_fslot_q <= finished_slot_i;
      in_cnt_q   <= in_cnt;
    end
  end

  // --------------------------------------------------------------------------
  // admission state
  // --------------------------------------------------------------------------
  mrac_pkg::cnt_vec_t                pend_mem_q [mrac_pkg::PEND_DEPTH];
  mrac_pkg::cnt_vec_t                run_tab_q  [mrac_pkg::RUN_DEPTH];
  logic [mrac_pkg::PEND_AW-1:0]      fifo_head_q, fifo_head_d;
  logic [mrac_pkg::PEND_AW-1:0]      fifo_tail_q, fifo_tail_d;
  logic [mrac_pkg::FILL_W-1:0]       fifo_fill_q, fifo_fill_d;
  logic [mrac_pkg::RUN_DEPTH-1:0]    slot_valid_q, slot_valid_d;
  mrac_pkg::cnt_vec_t                totals_q, totals_d;

  // result descriptor of the item being emitted
  logic [mrac_pkg::RES_CNT_W-1:0]    rem_q, rem_d;
  logic [mrac_pkg::TYPE_W-1:0]       idx_q, idx_d;
  logic                              stat_mode_q, stat_mode_d;
  mrac_pkg::cnt_vec_t                stat_q, stat_d;
  mrac_pkg::event_e                  r0_ev_q, r0_ev_d;
  logic [mrac_pkg::RUN_AW-1:0]       r0_slot_q, r0_slot_d;
  logic [mrac_pkg::RUN_AW-1:0]       r1_slot_q, r1_slot_d;

  // execute decode
  mrac_pkg::cnt_vec_t                head_cnt;
  mrac_pkg::cnt_vec_t                sum_tot;
  mrac_pkg::cnt_vec_t                sub_tot;
  logic [mrac_pkg::NUM_TYPES-1:0]    fit_vec;
  logic [mrac_pkg::RUN_AW-1:0]       free_slot;
  logic                              any_free;
  logic                              push_go;
  logic                              start_go;
  logic                              release_go;
  logic                              try_head;
  logic [mrac_pkg::FILL_W-1:0]       fill_push;

  // the last result may leave while the next item executes
  assign exec_go = in_vld_q && ((rem_q == '0) ||
                   ((rem_q == mrac_pkg::RES_CNT_W'(1)) && emit_go));

  always_comb begin
    logic [mrac_pkg::COUNT_WIDTH:0] sum_w;
    push_go = exec_go && (in_cmd_q == mrac_pkg::CMD_SUBMIT) &&
              (fifo_fill_q != mrac_pkg::FILL_W'(mrac_pkg::PEND_DEPTH));
    fill_push = fifo_fill_q + mrac_pkg::FILL_W'(push_go);

    // on an empty fifo the head is the item being pushed
    head_cnt = (fifo_fill_q == '0) ? in_cnt_q : pend_mem_q[fifo_head_q];

    for (int t = 0; t < mrac_pkg::NUM_TYPES; t++) begin
      sum_w      = {1'b0, totals_q[t]} + {1'b0, head_cnt[t]};
      fit_vec[t] = sum_w <= {1'b0, lim_q[t]};
      sum_tot[t] = sum_w[mrac_pkg::COUNT_WIDTH-1:0];
      sub_tot[t] = totals_q[t] - run_tab_q[in_fslot_q][t];
    end

    // lowest free slot
    any_free  = ~&slot_valid_q;
    free_slot = '0;
    for (int s = mrac_pkg::RUN_DEPTH - 1; s >= 0; s--) begin
      if (!slot_valid_q[s]) begin
        free_slot = mrac_pkg::RUN_AW'(s);
      end
    end

    try_head   = exec_go && ((in_cmd_q == mrac_pkg::CMD_SUBMIT) ||
                             (in_cmd_q == mrac_pkg::CMD_POLL));
    start_go   = try_head && (fill_push != '0) && (&fit_vec) && any_free;
    release_go = exec_go && (in_cmd_q == mrac_pkg::CMD_FINISH) &&
                 slot_valid_q[in_fslot_q];

    // fifo pointers
    fifo_tail_d = fifo_tail_q;
    fifo_head_d = fifo_head_q;
    if (push_go) begin
      fifo_tail_d = (fifo_tail_q == mrac_pkg::PEND_AW'(mrac_pkg::PEND_DEPTH - 1)) ?
                    '0 : fifo_tail_q + mrac_pkg::PEND_AW'(1);
    end
    if (start_go) begin
      fifo_head_d = (fifo_head_q == mrac_pkg::PEND_AW'(mrac_pkg::PEND_DEPTH - 1)) ?
                    '0 : fifo_head_q + mrac_pkg::PEND_AW'(1);
    end
    fifo_fill_d = fill_push - mrac_pkg::FILL_W'(start_go);

    // running set
    slot_valid_d = slot_valid_q;
    totals_d     = totals_q;
    if (start_go) begin
      slot_valid_d[free_slot] = 1'b1;
      totals_d                = sum_tot;
    end else if (release_go) begin
      slot_valid_d[in_fslot_q] = 1'b0;
      totals_d                 = sub_tot;
    end

    // result descriptor
    rem_d       = rem_q;
    idx_d       = idx_q;
    stat_mode_d = stat_mode_q;
    stat_d      = stat_q;
    r0_ev_d     = r0_ev_q;
    r0_slot_d   = r0_slot_q;
    r1_slot_d   = r1_slot_q;
    if (exec_go) begin
      idx_d       = '0;
      stat_mode_d = 1'b0;
      r0_slot_d   = '0;
      r1_slot_d   = free_slot;
      case (in_cmd_q)
        mrac_pkg::CMD_SUBMIT: begin
          r0_ev_d = push_go ? mrac_pkg::EV_QUEUED : mrac_pkg::EV_REJECTED;
          rem_d   = mrac_pkg::RES_CNT_W'(1) + mrac_pkg::RES_CNT_W'(start_go);
        end
        mrac_pkg::CMD_FINISH: begin
          r0_ev_d   = release_go ? mrac_pkg::EV_RELEASED : mrac_pkg::EV_UNKNOWN;
          r0_slot_d = in_fslot_q;
          rem_d     = mrac_pkg::RES_CNT_W'(1);
        end
        mrac_pkg::CMD_POLL: begin
          r0_ev_d   = mrac_pkg::EV_STARTED;
          r0_slot_d = free_slot;
          rem_d     = mrac_pkg::RES_CNT_W'(start_go);
        end
        mrac_pkg::CMD_STATUS: begin
          // totals are frozen into the descriptor so later items may run on
          r0_ev_d     = mrac_pkg::EV_STATUS;
          stat_mode_d = 1'b1;
          stat_d      = totals_q;
          rem_d       = mrac_pkg::RES_CNT_W'(mrac_pkg::NUM_TYPES);
        end
        default: begin
          r0_ev_d = mrac_pkg::EV_UNKNOWN;
          rem_d   = '0;
        end
      endcase
    end else if (emit_go) begin
      rem_d = rem_q - mrac_pkg::RES_CNT_W'(1);
      idx_d = idx_q + mrac_pkg::TYPE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_head_q  <= '0;
      fifo_tail_q  <= '0;
      fifo_fill_q  <= '0;
      slot_valid_q <= '0;
      totals_q     <= '0;
      rem_q        <= '0;
    end else begin
      fifo_head_q  <= fifo_head_d;
      fifo_tail_q  <= fifo_tail_d;
      fifo_fill_q  <= fifo_fill_d;
      slot_valid_q <= slot_valid_d;
      totals_q     <= totals_d;
      rem_q        <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    stat_mode_q <= stat_mode_d;
    stat_q      <= stat_d;
    r0_ev_q     <= r0_ev_d;
    r0_slot_q   <= r0_slot_d;
    r1_slot_q   <= r1_slot_d;
  end

  // storage arrays, no reset
  always_ff @(posedge clk_i) begin
    if (push_go) begin
      pend_mem_q[fifo_tail_q] <= in_cnt_q;
    end
    if (start_go) begin
      run_tab_q[free_slot] <= head_cnt;
    end
  end

  // --------------------------------------------------------------------------
  // result emitter and output register
  // --------------------------------------------------------------------------
  logic                              out_vld_q;
  mrac_pkg::event_e                  out_ev_q, emit_ev;
  logic [mrac_pkg::RUN_AW-1:0]       out_slot_q, emit_slot;
  logic [mrac_pkg::TYPE_W-1:0]       out_type_q, emit_type;
  logic [mrac_pkg::COUNT_WIDTH-1:0]  out_cnt_q, emit_cnt;
  logic                              out_last_q;

  assign emit_go = (rem_q != '0) && (!out_vld_q || out_ready_i);

  always_comb begin
    emit_type = '0;
    emit_cnt  = '0;
    if (stat_mode_q) begin
      emit_ev   = mrac_pkg::EV_STATUS;
      emit_slot = '0;
      emit_type = idx_q;
      emit_cnt  = stat_q[idx_q];
    end else if (idx_q == '0) begin
      emit_ev   = r0_ev_q;
      emit_slot = r0_slot_q;
    end else begin
      // second result of a submit is always the start of the head
      emit_ev   = mrac_pkg::EV_STARTED;
      emit_slot = r1_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_go) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_ev_q   <= emit_ev;
      out_slot_q <= emit_slot;
      out_type_q <= emit_type;
      out_cnt_q  <= emit_cnt;
      out_last_q <= (rem_q == mrac_pkg::RES_CNT_W'(1));
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_res_o     = out_ev_q;
  assign task_slot_o     = out_slot_q;
  assign type_index_o    = out_type_q;
  assign running_count_o = out_cnt_q;
  assign last_o          = out_last_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `MRAC_ASSERT(a_fill_bound, fifo_fill_q <= mrac_pkg::FILL_W'(mrac_pkg::PEND_DEPTH), "fifo fill above depth")

  `MRAC_ASSERT(a_start_free_slot, !start_go || !slot_valid_q[free_slot], "start into a busy slot")

  `MRAC_ASSERT(a_rem_bound, rem_q <= mrac_pkg::RES_CNT_W'(mrac_pkg::NUM_TYPES), "too many pending results")

  `MRAC_ASSERT_NEXT(a_last_flag, emit_go && (rem_q == mrac_pkg::RES_CNT_W'(1)), out_vld_q && out_last_q, "final result without last")

  `MRAC_ASSERT_NEXT(a_release_clears, release_go, !slot_valid_q[$past(in_fslot_q)], "released slot still valid")

endmodule

`default_nettype wire
